@@ hw/rtl/novelty_lowest_cost_table_top_macros.svh @@
// Assertion macros shared by the novelty table RTL.
`ifndef NOVELTY_LOWEST_COST_TABLE_TOP_MACROS_SVH
`define NOVELTY_LOWEST_COST_TABLE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define NLCT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("nlct assertion failed");
`define NLCT_ASSERT_IN_RESET(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("nlct assertion failed");
`else
`define NLCT_ASSERT(lbl, prop)
`define NLCT_ASSERT_IN_RESET(lbl, prop)
`endif
`endif

@@ hw/rtl/nlct_pkg.sv @@
// Types and constants shared by the novelty lowest-cost table.
`timescale 1ns / 1ps
package nlct_pkg;

  localparam int VAR_W   = 6;
  localparam int VALUE_W = 4;
  localparam int COST_W  = 16;
  localparam int COUNT_W = 7;
  localparam int SCORE_W = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

  typedef struct packed {
    logic [VAR_W-1:0]   fact_var;
    logic [VALUE_W-1:0] fact_value;
    logic [COST_W-1:0]  state_cost;
    logic               cost_infinite;
    logic               last_fact;
  } fact_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] novelty_score;
    logic                      unsolvable;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic update;
    logic clear;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic clear_last;
    logic last;
  } status_t;

endpackage

@@ hw/rtl/novelty_lowest_cost_table_top.sv @@
// Top level of the novelty lowest-cost table.
`timescale 1ns / 1ps
`include "novelty_lowest_cost_table_top_macros.svh"
// Each fact beat has two steps: the accept cycle reads the cost table, and
// the following cycle compares, writes the table back and updates the
// counts, so busy is high in the cycle after each accepted beat. The
// single-port table memory is why the two steps are split. After reset a
// clearing pass walks the table one entry a cycle, NUM_VARS * NUM_VALUES
// entries (1024 at the defaults), with busy high throughout. A result
// appears on result with done high for exactly one cycle, registered by
// the lookup of a state's last fact, and is taken at the next edge; the
// receiver cannot stall it, so it must take every result beat as it comes.
module novelty_lowest_cost_table_top #(
  parameter int NUM_VARS   = 64,
  parameter int NUM_VALUES = 16,
  parameter int COST_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  nlct_pkg::fact_t   fact,
  output logic              done,
  output nlct_pkg::result_t result
);

  nlct_pkg::cmd_t    cmd;
  nlct_pkg::status_t status;

  nlct_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  nlct_dp #(
    .NUM_VARS   (NUM_VARS),
    .NUM_VALUES (NUM_VALUES),
    .COST_WIDTH (COST_WIDTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .fact   (fact),
    .status (status),
    .result (result)
  );

  `NLCT_ASSERT(a_unsolvable_zero_score, (done && result.unsolvable) |-> (result.novelty_score == '0))

endmodule

@@ hw/rtl/nlct_ctrl.sv @@
// Controller state machine: clearing pass, idle and lookup sequencing.
`timescale 1ns / 1ps
`include "novelty_lowest_cost_table_top_macros.svh"
module nlct_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  nlct_pkg::status_t status,
  output nlct_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              done
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  state_t state;

  assign cmd.accept = (state == ST_IDLE) && start;
  assign cmd.update = (state == ST_LOOKUP);
  assign cmd.clear  = (state == ST_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          if (status.clear_last) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
          end
        end
        ST_IDLE: begin
          if (start) begin
            state <= ST_LOOKUP;
            busy  <= 1'b1;
          end
        end
        ST_LOOKUP: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
          done  <= status.last;
        end
        default: begin
          state <= ST_CLEAR;
          busy  <= 1'b1;
        end
      endcase
    end
  end

  `NLCT_ASSERT(a_done_follows_lookup, done |-> $past(state == ST_LOOKUP))
  `NLCT_ASSERT(a_busy_matches_state, busy != (state == ST_IDLE))
  `NLCT_ASSERT_IN_RESET(a_no_done_after_reset, rst |=> !done)

endmodule

@@ hw/rtl/nlct_dp.sv @@
// Datapath: cost table memory, compare, saturating counts and result register.
`timescale 1ns / 1ps
`include "novelty_lowest_cost_table_top_macros.svh"
module nlct_dp #(
  parameter int NUM_VARS   = 64,
  parameter int NUM_VALUES = 16,
  parameter int COST_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  nlct_pkg::cmd_t    cmd,
  input  nlct_pkg::fact_t   fact,
  output nlct_pkg::status_t status,
  output nlct_pkg::result_t result
);

  localparam int DEPTH   = NUM_VARS * NUM_VALUES;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int STORE_W = (COST_WIDTH < nlct_pkg::COST_W) ? COST_WIDTH : nlct_pkg::COST_W;
  localparam int WORD_W  = STORE_W + 1;
  localparam int CNT_W   = nlct_pkg::COUNT_W;

  // Each word holds a seen flag above the lowest cost.
  logic [WORD_W-1:0] mem [DEPTH];

  logic              in_range;
  logic [IDX_W-1:0]  rd_idx;
  logic [WORD_W-1:0] rd_word;
  logic [IDX_W-1:0]  idx_q;
  logic [STORE_W-1:0] cost_q;
  logic              use_q;
  logic              inf_q;
  logic              last_q;
  logic [IDX_W-1:0]  clr_addr;
  logic [CNT_W-1:0]  novel_cnt;
  logic [CNT_W-1:0]  nonnovel_cnt;
  logic [CNT_W-1:0]  novel_cnt_next;
  logic [CNT_W-1:0]  nonnovel_cnt_next;
  logic              hit_valid;
  logic [STORE_W-1:0] stored_cost;
  logic              is_novel;
  logic              is_worse;
  nlct_pkg::result_t result_q;

  assign in_range = (32'(fact.fact_var) < NUM_VARS) && (32'(fact.fact_value) < NUM_VALUES);
  assign rd_idx   = in_range ?
                    IDX_W'(32'(fact.fact_var) * NUM_VALUES + 32'(fact.fact_value)) : '0;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_word <= mem[rd_idx];
      idx_q   <= rd_idx;
      cost_q  <= fact.state_cost[STORE_W-1:0];
      use_q   <= in_range && !fact.cost_infinite;
      inf_q   <= fact.cost_infinite;
      last_q  <= fact.last_fact;
    end
    if (cmd.clear) begin
      mem[clr_addr] <= '0;
    end else if (cmd.update && is_novel) begin
      mem[idx_q] <= {1'b1, cost_q};
    end
  end

  assign hit_valid   = rd_word[STORE_W];
  assign stored_cost = rd_word[STORE_W-1:0];
  assign is_novel    = use_q && (!hit_valid || (cost_q < stored_cost));
  assign is_worse    = use_q && hit_valid && (cost_q > stored_cost);

  assign novel_cnt_next    = (is_novel && (novel_cnt != nlct_pkg::COUNT_MAX)) ?
                             novel_cnt + 1'b1 : novel_cnt;
  assign nonnovel_cnt_next = (is_worse && (nonnovel_cnt != nlct_pkg::COUNT_MAX)) ?
                             nonnovel_cnt + 1'b1 : nonnovel_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      novel_cnt    <= '0;
      nonnovel_cnt <= '0;
      clr_addr     <= '0;
    end else begin
      if (cmd.clear) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.update) begin
        if (last_q) begin
          novel_cnt    <= '0;
          nonnovel_cnt <= '0;
        end else begin
          novel_cnt    <= novel_cnt_next;
          nonnovel_cnt <= nonnovel_cnt_next;
        end
      end
    end
  end

  // An infinite last fact reports an unsolvable state with a zero score.
  always_ff @(posedge clk) begin
    if (cmd.update && last_q) begin
      if (inf_q) begin
        result_q.novelty_score <= '0;
        result_q.unsolvable    <= 1'b1;
      end else if (novel_cnt_next != '0) begin
        result_q.novelty_score <= nlct_pkg::SCORE_W'(8'd0 - {1'b0, novel_cnt_next});
        result_q.unsolvable    <= 1'b0;
      end else begin
        result_q.novelty_score <= {1'b0, nonnovel_cnt_next};
        result_q.unsolvable    <= 1'b0;
      end
    end
  end

  assign result            = result_q;
  assign status.clear_last = (clr_addr == IDX_W'(DEPTH - 1));
  assign status.last       = last_q;

  `NLCT_ASSERT(a_counts_clear_on_last, (cmd.update && last_q) |=> ((novel_cnt == '0) && (nonnovel_cnt == '0)))
  `NLCT_ASSERT(a_clear_addr_holds, !cmd.clear |=> $stable(clr_addr))

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the novelty lowest-cost table top level.
`timescale 1ns / 1ps
module tb;

  localparam int TABLE_DEPTH    = 1024;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_FACTS   = 1520;
  localparam int DRAIN_CYCLES   = 8;

  logic              clk   = 1'b0;
  logic              rst   = 1'b1;
  logic              start = 1'b0;
  nlct_pkg::fact_t   fact  = '0;
  logic              busy;
  logic              done;
  nlct_pkg::result_t result;

  // Own copy of the cost table and the per-state counts.
  logic [nlct_pkg::COST_W-1:0]  lowest_seen [TABLE_DEPTH];
  bit                           entry_seen  [TABLE_DEPTH];
  logic [nlct_pkg::COUNT_W-1:0] novel_n;
  logic [nlct_pkg::COUNT_W-1:0] stale_n;

  nlct_pkg::result_t pending_scores[$];
  int      errors        = 0;
  int      quiet_cycles  = 0;
  bit      steady_sender = 1'b0;

  novelty_lowest_cost_table_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .fact   (fact),
    .done   (done),
    .result (result)
  );

  always #4 clk = ~clk;

  function automatic logic [nlct_pkg::COUNT_W-1:0] bump(
      input logic [nlct_pkg::COUNT_W-1:0] c);
    return (c == nlct_pkg::COUNT_MAX) ? c : c + 1'b1;
  endfunction

  // Updates the table copy for one accepted fact and queues the score when
  // the fact closes its state.
  function automatic void judge_fact(input nlct_pkg::fact_t f);
    logic [9:0]                          idx;
    nlct_pkg::result_t                   r;
    logic signed [nlct_pkg::SCORE_W-1:0] score;
    idx = {f.fact_var, f.fact_value};
    if (!f.cost_infinite) begin
      if (!entry_seen[idx] || f.state_cost < lowest_seen[idx]) begin
        lowest_seen[idx] = f.state_cost;
        entry_seen[idx]  = 1'b1;
        novel_n          = bump(novel_n);
      end else if (f.state_cost > lowest_seen[idx]) begin
        stale_n = bump(stale_n);
      end
    end
    if (f.last_fact) begin
      if (f.cost_infinite)
        score = '0;
      else if (novel_n != '0)
        score = -$signed({1'b0, novel_n});
      else
        score = $signed({1'b0, stale_n});
      r.novelty_score = score;
      r.unsolvable    = f.cost_infinite;
      pending_scores.push_back(r);
      novel_n = '0;
      stale_n = '0;
    end
  endfunction

  initial begin
    novel_n = '0;
    stale_n = '0;
    foreach (entry_seen[i]) entry_seen[i] = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && start && !busy)
      judge_fact(fact);
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_scores.size() == 0) begin
        $error("result beat with nothing expected: novelty_score %0d unsolvable %0b",
               result.novelty_score, result.unsolvable);
        errors++;
      end else begin
        nlct_pkg::result_t exp;
        exp = pending_scores.pop_front();
        if (result.novelty_score !== exp.novelty_score) begin
          $error("novelty_score: expected %0d, got %0d",
                 exp.novelty_score, result.novelty_score);
          errors++;
        end
        if (result.unsolvable !== exp.unsolvable) begin
          $error("unsolvable: expected %0b, got %0b", exp.unsolvable, result.unsolvable);
          errors++;
        end
      end
    end
  end

  // Ends the run when no beat moves in either direction for too long.
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL novelty_lowest_cost_table_top");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic nlct_pkg::fact_t mk_fact(input int unsigned v, input int unsigned val,
                                              input int unsigned cost, input bit inf,
                                              input bit last);
    nlct_pkg::fact_t f;
    f.fact_var      = v[nlct_pkg::VAR_W-1:0];
    f.fact_value    = val[nlct_pkg::VALUE_W-1:0];
    f.state_cost    = cost[nlct_pkg::COST_W-1:0];
    f.cost_infinite = inf;
    f.last_fact     = last;
    return f;
  endfunction

  task automatic send_fact(input nlct_pkg::fact_t f);
    int unsigned gap;
    gap = steady_sender ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    fact  <= f;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic end_phase();
    start <= 1'b0;
    @(posedge clk);
    while (pending_scores.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    // Unseen fact, then equal, higher and lower costs on the same entry.
    send_fact(mk_fact(0, 0, 100, 1'b0, 1'b1));
    send_fact(mk_fact(0, 0, 100, 1'b0, 1'b1));
    send_fact(mk_fact(0, 0, 200, 1'b0, 1'b1));
    send_fact(mk_fact(0, 0, 50, 1'b0, 1'b1));
    // Extremes of index and cost; novel wins over non-novel.
    send_fact(mk_fact(63, 15, 65535, 1'b0, 1'b0));
    send_fact(mk_fact(0, 0, 65535, 1'b0, 1'b1));
    send_fact(mk_fact(63, 15, 0, 1'b0, 1'b1));
    send_fact(mk_fact(63, 15, 65535, 1'b0, 1'b1));
    // An infinite cost must leave the entry unwritten.
    send_fact(mk_fact(1, 1, 0, 1'b1, 1'b1));
    send_fact(mk_fact(1, 1, 65535, 1'b0, 1'b1));
    // Mixed infinity: only the flag of the last fact sets unsolvable.
    send_fact(mk_fact(2, 2, 7, 1'b1, 1'b0));
    send_fact(mk_fact(3, 3, 7, 1'b0, 1'b1));
    send_fact(mk_fact(4, 4, 10, 1'b0, 1'b0));
    send_fact(mk_fact(5, 5, 10, 1'b1, 1'b1));
    send_fact(mk_fact(4, 4, 10, 1'b0, 1'b1));
    send_fact(mk_fact(2, 2, 7, 1'b0, 1'b1));
    send_fact(mk_fact(5, 5, 10, 1'b0, 1'b1));
    send_fact(mk_fact(42, 10, 43690, 1'b0, 1'b0));
    send_fact(mk_fact(21, 5, 21845, 1'b0, 1'b1));
    end_phase();
  endtask

  task automatic test_saturation();
    // Falling costs on one entry make every beat novel.
    for (int i = 0; i < 130; i++)
      send_fact(mk_fact(10, 3, 1000 - i, 1'b0, i == 129));
    for (int i = 0; i < 130; i++)
      send_fact(mk_fact(10, 3, 60000, 1'b0, i == 129));
    end_phase();
  endtask

  task automatic test_random();
    int unsigned sent;
    int unsigned n_facts, var_hi, val_hi, mode;
    bit          state_inf, mixed;
    logic [nlct_pkg::COST_W-1:0] base, cost;
    bit          inf;
    sent = 0;
    while (sent < RANDOM_FACTS) begin
      n_facts = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                            : $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        var_hi = $urandom_range(0, 7);
        val_hi = $urandom_range(0, 3);
      end else begin
        var_hi = 63;
        val_hi = 15;
      end
      mode = $urandom_range(0, 3);
      case (mode)
        0:       base = nlct_pkg::COST_W'($urandom_range(0, 15));
        1:       base = nlct_pkg::COST_W'($urandom_range(0, 255));
        2:       base = nlct_pkg::COST_W'($urandom);
        default: base = $urandom_range(0, 1) ? '1 : '0;
      endcase
      state_inf     = ($urandom_range(0, 9) == 0);
      mixed         = ($urandom_range(0, 7) == 0);
      steady_sender = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n_facts; i++) begin
        cost = mixed ? base + nlct_pkg::COST_W'($urandom_range(0, 3)) : base;
        inf  = mixed ? 1'($urandom_range(0, 1)) : state_inf;
        send_fact(mk_fact($urandom_range(0, var_hi), $urandom_range(0, val_hi),
                          32'(cost), inf, i == n_facts - 1));
        sent++;
      end
    end
    steady_sender = 1'b0;
    end_phase();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_saturation();
    test_random();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("PASS novelty_lowest_cost_table_top");
    else
      $display("FAIL novelty_lowest_cost_table_top");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/nlct_pkg.sv
hw/rtl/nlct_ctrl.sv
hw/rtl/nlct_dp.sv
hw/rtl/novelty_lowest_cost_table_top.sv
tb/tb.sv
